/* design/okvt_pkg.sv */
// Package for the ordered key/value table.
// Holds table sizes, request kinds and the control struct driven into the cell row.
// No dependencies.
package okvt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_SET    = 2'd1,
    KIND_DELETE = 2'd2
  } kind_t;

  typedef struct packed {
    logic                  en;
    logic [1:0]            kind;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic                  hit;
  } cell_ctrl_t;

endpackage

/* design/okvt_ifs.sv */
// Request and result channel interfaces of the ordered key/value table.
// Depends on okvt_pkg for field widths.
interface okvt_in_if;
  import okvt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;
  modport source (output valid, output kind, output key, output value, input ready);
  modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface okvt_out_if;
  import okvt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [VALUE_BITS-1:0] value_out;
  logic [COUNT_W-1:0]    entry_count;
  logic                  dropped;
  modport source (output valid, output found, output value_out, output entry_count,
                  output dropped, input ready);
  modport sink   (input valid, input found, input value_out, input entry_count,
                  input dropped, output ready);
endinterface

/* design/okvt_cell.sv */
// One cell of the table row: holds a key/value pair and its valid bit.
// Compares its key, passes the delete shift and value result to the next cell.
// Depends on okvt_pkg.
module okvt_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  okvt_pkg::cell_ctrl_t            ctrl,
  input  logic                            prev_valid,
  input  logic [okvt_pkg::KEY_BITS-1:0]   next_key,
  input  logic [okvt_pkg::VALUE_BITS-1:0] next_value,
  input  logic                            next_valid,
  input  logic                            shift_in,
  input  logic [okvt_pkg::VALUE_BITS-1:0] vacc_in,
  output logic [okvt_pkg::KEY_BITS-1:0]   key_q,
  output logic [okvt_pkg::VALUE_BITS-1:0] value_q,
  output logic                            valid_q,
  output logic                            shift_out,
  output logic [okvt_pkg::VALUE_BITS-1:0] vacc_out
);
  import okvt_pkg::*;

  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic                  valid_r, valid_nxt;
  logic                  kind_ok;
  logic                  match;

  assign kind_ok   = (ctrl.kind == KIND_LOOKUP) || (ctrl.kind == KIND_SET) ||
                     (ctrl.kind == KIND_DELETE);
  assign match     = valid_r && kind_ok && (key_r == ctrl.key);
  assign shift_out = shift_in | match;
  assign vacc_out  = vacc_in | (match ? value_r : '0);
  assign key_q     = key_r;
  assign value_q   = value_r;
  assign valid_q   = valid_r;

  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.en) begin
      case (ctrl.kind)
        KIND_SET: begin
          if (ctrl.hit && match) begin
            value_nxt = ctrl.value;
          end else if (!ctrl.hit && !valid_r && prev_valid) begin
            key_nxt   = ctrl.key;
            value_nxt = ctrl.value;
            valid_nxt = 1'b1;
          end
        end
        KIND_DELETE: begin
          if (ctrl.hit && shift_out) begin
            key_nxt   = next_key;
            value_nxt = next_value;
            valid_nxt = next_valid;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

/* design/ordered_key_value_table.sv */
// Top level of the ordered key/value table: request register, cell row, result register.
// Depends on okvt_pkg, okvt_ifs and okvt_cell.
//
//   channel   | dir | payload
//   in_chan   | in  | kind, key, value
//   out_chan  | out | found, value_out, entry_count, dropped
//
// One request per cycle sustained unless the result stalls; an accepted request is
// first held in the request register, then the cell row updates and result registers.
// The cell row compares all keys combinationally and shifts on delete in the same cycle.
// Reset clears the valid bits, the entry count and both handshake stages.
// A stalled result holds the request register; in_chan.ready drops until it drains.
module ordered_key_value_table (
  input  logic        clk,
  input  logic        rst_n,
  okvt_in_if.sink     in_chan,
  okvt_out_if.source  out_chan
);
  import okvt_pkg::*;

  logic                  req_vld_r, req_vld_nxt;
  logic [1:0]            req_kind_r;
  logic [KEY_BITS-1:0]   req_key_r;
  logic [VALUE_BITS-1:0] req_value_r;

  logic                  out_vld_r, out_vld_nxt;
  logic                  found_r;
  logic [VALUE_BITS-1:0] vout_r;
  logic [COUNT_W-1:0]    cnt_out_r;
  logic                  dropped_r;

  logic [COUNT_W-1:0]    count_r, count_nxt;

  logic                  exec;
  logic                  accept;
  logic                  hit;
  logic                  full;
  logic                  drop;
  cell_ctrl_t            ctrl;

  logic [KEY_BITS-1:0]   keys   [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] values [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valids;
  logic [TABLE_DEPTH:0]  shift;
  logic [VALUE_BITS-1:0] vacc [TABLE_DEPTH+1];

  assign exec          = req_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !req_vld_r || exec;
  assign accept        = in_chan.valid && in_chan.ready;

  assign shift[0] = 1'b0;
  assign vacc[0]  = '0;
  assign hit      = shift[TABLE_DEPTH];
  assign full     = valids[TABLE_DEPTH-1];
  assign drop     = (req_kind_r == KIND_SET) && !hit && full;

  assign ctrl.en    = exec;
  assign ctrl.kind  = req_kind_r;
  assign ctrl.key   = req_key_r;
  assign ctrl.value = req_value_r;
  assign ctrl.hit   = hit;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                  prev_v;
    logic [KEY_BITS-1:0]   nk;
    logic [VALUE_BITS-1:0] nv;
    logic                  nvld;
    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = valids[i-1];
    end
    if (i == TABLE_DEPTH-1) begin : g_last
      assign nk   = '0;
      assign nv   = '0;
      assign nvld = 1'b0;
    end else begin : g_inner
      assign nk   = keys[i+1];
      assign nv   = values[i+1];
      assign nvld = valids[i+1];
    end
    okvt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_valid (prev_v),
      .next_key   (nk),
      .next_value (nv),
      .next_valid (nvld),
      .shift_in   (shift[i]),
      .vacc_in    (vacc[i]),
      .key_q      (keys[i]),
      .value_q    (values[i]),
      .valid_q    (valids[i]),
      .shift_out  (shift[i+1]),
      .vacc_out   (vacc[i+1])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (exec) begin
      case (req_kind_r)
        KIND_SET: begin
          if (!hit && !full) begin
            count_nxt = count_r + COUNT_W'(1);
          end
        end
        KIND_DELETE: begin
          if (hit) begin
            count_nxt = count_r - COUNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    req_vld_nxt = req_vld_r;
    if (accept) begin
      req_vld_nxt = 1'b1;
    end else if (exec) begin
      req_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (exec) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind_r  <= in_chan.kind;
      req_key_r   <= in_chan.key;
      req_value_r <= in_chan.value;
    end
    if (exec) begin
      found_r   <= hit;
      vout_r    <= vacc[TABLE_DEPTH];
      cnt_out_r <= count_nxt;
      dropped_r <= drop;
    end
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      count_r   <= '0;
    end else begin
      req_vld_r <= req_vld_nxt;
      out_vld_r <= out_vld_nxt;
      count_r   <= count_nxt;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.found       = found_r;
  assign out_chan.value_out   = vout_r;
  assign out_chan.entry_count = cnt_out_r;
  assign out_chan.dropped     = dropped_r;

endmodule
